// ===== hw/rtl/pcob_pkg.sv =====
// Shared types and constants of the point cloud obstacle binner.
// No dependencies.
package pcob_pkg;

  typedef enum logic {
    OpBin   = 1'b0,
    OpClear = 1'b1
  } op_e;

  typedef logic [1:0] mark_t;

  localparam mark_t MarkFree    = 2'd0;
  localparam mark_t MarkCluster = 2'd1;
  localparam mark_t MarkLoose   = 2'd2;

  localparam logic [7:0] ColourFull = 8'hFF;

  localparam int unsigned CellUnits     = 80;
  localparam int unsigned LateralOffset = 20480;
  localparam int unsigned ForwardBias   = 4915;

  // divide by 80: shift by 4, then multiply by the reciprocal of 5
  localparam int unsigned XW         = 14;
  localparam int unsigned RecipShift = 18;
  localparam int unsigned ProdW      = 30;
  localparam int unsigned QuotW      = ProdW - RecipShift;
  localparam logic [15:0] Recip5     = 16'd52429;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic  is_clear;
    logic  red;
    mark_t mark;
  } cmd_ctl_t;

  typedef struct packed {
    logic clearing;
  } bk_status_t;

  typedef enum logic [1:0] {
    BkClear,
    BkIdle,
    BkCheck
  } bk_state_e;

endpackage

// ===== hw/rtl/pcob_if.sv =====
// Channel interfaces of the point cloud obstacle binner: point words in,
// obstacle words out. No dependencies.
interface pcob_pt_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [17:0] lateral_pos;
  logic signed [17:0] forward_pos;
  logic        [7:0]  red_level;
  logic        [7:0]  green_level;
  logic        [7:0]  blue_level;

  modport source (
    output valid, op, lateral_pos, forward_pos, red_level, green_level, blue_level,
    input  ready
  );
  modport sink (
    input  valid, op, lateral_pos, forward_pos, red_level, green_level, blue_level,
    output ready
  );
endinterface

interface pcob_obs_if;
  logic               valid;
  logic               ready;
  logic        [15:0] obstacle_forward;
  logic signed [15:0] obstacle_lateral;

  modport source (
    output valid, obstacle_forward, obstacle_lateral,
    input  ready
  );
  modport sink (
    input  valid, obstacle_forward, obstacle_lateral,
    output ready
  );
endinterface

// ===== hw/rtl/pcob_front.sv =====
// Front end: accepts point words, bins coordinates into row and column,
// drops skipped and off-grid points and pushes commands. Depends on pcob_pkg, pcob_if.
module pcob_front
  import pcob_pkg::*;
#(
  parameter int unsigned GridSide = 512,
  localparam int unsigned IdxW = $clog2(GridSide),
  localparam int unsigned CmdW = $bits(cmd_ctl_t) + 2 * IdxW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pcob_pt_if.sink          pt_i,
  input  bk_status_t       status_i,
  output logic             push_o,
  output logic [CmdW-1:0]  cmd_o,
  input  logic             full_i
);

  logic signed [18:0] lat_sum;
  logic               lat_far, fwd_far;
  logic [XW-1:0]      lat_x, fwd_x;
  logic               acc, f_free, need, in_grid;
  logic [ProdW-1:0]   prod_r, prod_c;
  logic [QuotW-1:0]   q_r, q_c;
  cmd_ctl_t           ctl;

  logic               f_vld_q, f_vld_d;
  logic               f_clr_q, f_skip_q, f_red_q;
  mark_t              f_mark_q;
  logic [XW-1:0]      f_xr_q, f_xc_q;

  assign lat_sum = $signed({pt_i.lateral_pos[17], pt_i.lateral_pos}) + 19'sd20480;
  assign lat_far = lat_sum < -19'sd79;
  assign fwd_far = pt_i.forward_pos < -18'sd79;
  assign lat_x   = lat_sum[18] ? '0 : lat_sum[17:4];
  assign fwd_x   = pt_i.forward_pos[17] ? '0 : {1'b0, pt_i.forward_pos[16:4]};

  assign prod_r  = ProdW'(f_xr_q) * ProdW'(Recip5);
  assign prod_c  = ProdW'(f_xc_q) * ProdW'(Recip5);
  assign q_r     = prod_r[ProdW-1:RecipShift];
  assign q_c     = prod_c[ProdW-1:RecipShift];
  assign in_grid = (q_r < QuotW'(GridSide)) && (q_c < QuotW'(GridSide));

  assign need       = f_vld_q && (f_clr_q || (!f_skip_q && in_grid));
  assign push_o     = need && !full_i;
  assign f_free     = !f_vld_q || !need || !full_i;
  assign pt_i.ready = f_free && !status_i.clearing;
  assign acc        = pt_i.valid && pt_i.ready;
  assign f_vld_d    = acc || (f_vld_q && !f_free);

  assign ctl   = '{is_clear: f_clr_q, red: f_red_q, mark: f_mark_q};
  assign cmd_o = {ctl, q_r[IdxW-1:0], q_c[IdxW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= f_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f_clr_q  <= (pt_i.op == OpClear);
      f_skip_q <= (pt_i.green_level == ColourFull) || lat_far || fwd_far;
      f_red_q  <= (pt_i.red_level == ColourFull);
      f_mark_q <= (pt_i.blue_level == ColourFull) ? MarkLoose : MarkCluster;
      f_xr_q   <= lat_x;
      f_xc_q   <= fwd_x;
    end
  end

endmodule

// ===== hw/rtl/pcob_queue.sv =====
// Command queue between front and back end of the binner.
// Depends on nothing beyond its parameters.
module pcob_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/pcob_back.sv =====
// Back end: owns the cell mark memory, runs the clearing pass, does the
// read-modify-write per point and holds the obstacle word. Depends on pcob_pkg, pcob_if.
module pcob_back
  import pcob_pkg::*;
#(
  parameter int unsigned GridSide = 512,
  localparam int unsigned IdxW = $clog2(GridSide),
  localparam int unsigned CmdW = $bits(cmd_ctl_t) + 2 * IdxW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CmdW-1:0] cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  pcob_obs_if.source      obs_o,
  output bk_status_t      status_o
);

  localparam int unsigned AddrW    = 2 * IdxW;
  localparam int unsigned MemDepth = 1 << AddrW;

  mark_t            mem [MemDepth];
  mark_t            rd_q;

  bk_state_e        state_q, state_d;
  logic [AddrW-1:0] clr_ptr_q, clr_ptr_d;
  cmd_ctl_t         cur_ctl_q, cur_ctl_d;
  logic [AddrW-1:0] cur_addr_q, cur_addr_d;
  logic             out_vld_q, out_vld_d;
  logic [15:0]      out_fwd_q, out_fwd_d;
  logic [15:0]      out_lat_q, out_lat_d;

  cmd_ctl_t         head_ctl;
  logic [AddrW-1:0] head_addr;
  logic             mem_we, mem_re, out_load;
  logic [AddrW-1:0] mem_wa;
  mark_t            mem_wd;
  logic [31:0]      fwd_full, lat_full;

  assign head_ctl  = cmd_i[CmdW-1:AddrW];
  assign head_addr = cmd_i[AddrW-1:0];

  assign fwd_full = 32'(cur_addr_q[IdxW-1:0]) * 32'(CellUnits) + 32'(ForwardBias);
  assign lat_full = 32'(cur_addr_q[AddrW-1:IdxW]) * 32'(CellUnits) - 32'(LateralOffset);

  assign status_o.clearing = (state_q == BkClear);

  always_comb begin
    state_d    = state_q;
    clr_ptr_d  = clr_ptr_q;
    cur_ctl_d  = cur_ctl_q;
    cur_addr_d = cur_addr_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wa     = cur_addr_q;
    mem_wd     = cur_ctl_q.mark;
    out_load   = 1'b0;
    case (state_q)
      BkClear: begin
        mem_we    = 1'b1;
        mem_wa    = clr_ptr_q;
        mem_wd    = MarkFree;
        clr_ptr_d = clr_ptr_q + 1'b1;
        if (clr_ptr_q == AddrW'(MemDepth - 1)) begin
          state_d = BkIdle;
        end
      end
      BkIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_ctl.is_clear) begin
            clr_ptr_d = '0;
            state_d   = BkClear;
          end else begin
            mem_re     = 1'b1;
            cur_ctl_d  = head_ctl;
            cur_addr_d = head_addr;
            state_d    = BkCheck;
          end
        end
      end
      BkCheck: begin
        if (rd_q != MarkFree) begin
          state_d = BkIdle;
        end else if (!(cur_ctl_q.red && out_vld_q && !obs_o.ready)) begin
          mem_we   = 1'b1;
          out_load = cur_ctl_q.red;
          state_d  = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase

    out_vld_d = out_load || (out_vld_q && !obs_o.ready);
    out_fwd_d = out_load ? fwd_full[15:0] : out_fwd_q;
    out_lat_d = out_load ? lat_full[15:0] : out_lat_q;
  end

  assign obs_o.valid            = out_vld_q;
  assign obs_o.obstacle_forward = out_fwd_q;
  assign obs_o.obstacle_lateral = $signed(out_lat_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkClear;
      clr_ptr_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_ctl_q  <= cur_ctl_d;
    cur_addr_q <= cur_addr_d;
    out_fwd_q  <= out_fwd_d;
    out_lat_q  <= out_lat_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[head_addr];
    end
  end

endmodule

// ===== hw/rtl/point_cloud_obstacle_binner.sv =====
// With an empty queue and an idle back end, a taken point word passes the front
// register, the queue, the mark memory read and the obstacle word register.
// A point in the grid holds the back end for the mark memory read, then the check and
// write, stalled while a red point meets an untaken obstacle word; a dropped point
// is never queued. A clear word and reset each clear all 4^ceil(log2 GridSide)
// mark memory cells (262144 at 512) in one pass, while no point word is taken.
module point_cloud_obstacle_binner
  import pcob_pkg::*;
#(
  parameter int unsigned GridSide = 512
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcob_pt_if.sink    pt_i,
  pcob_obs_if.source obs_o
);

  localparam int unsigned IdxW = $clog2(GridSide);
  localparam int unsigned CmdW = $bits(cmd_ctl_t) + 2 * IdxW;

  logic            push, pop, full, empty;
  logic [CmdW-1:0] cmd_in, cmd_out;
  bk_status_t      status;

  pcob_front #(.GridSide(GridSide)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pt_i     (pt_i),
    .status_i (status),
    .push_o   (push),
    .cmd_o    (cmd_in),
    .full_i   (full)
  );

  pcob_queue #(.Width(CmdW), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (cmd_out),
    .empty_o (empty)
  );

  pcob_back #(.GridSide(GridSide)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_out),
    .empty_i  (empty),
    .pop_o    (pop),
    .obs_o    (obs_o),
    .status_o (status)
  );

endmodule
